### rtl/tsrrs_pkg.sv
// Shared types and constants of the task slot round-robin scheduler.
package tsrrs_pkg;

  // request codes
  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_YIELD  = 2'd2;
  localparam logic [1:0] CMD_EXIT   = 2'd3;

  // result codes
  localparam logic [1:0] RC_DONE    = 2'd0;
  localparam logic [1:0] RC_NOSLOT  = 2'd1;
  localparam logic [1:0] RC_REFUSED = 2'd2;
  localparam logic [1:0] RC_IGNORED = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REQ_STACK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STACK_BASE = 1'b1;

  localparam logic [15:0] RESET_STACK_BYTES = 16'd1024;
  localparam logic [15:0] MIN_STACK_BYTES   = 16'd256;
  localparam logic [15:0] STACK_ALIGN_MASK  = 16'hFFFC;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] entry_handle;
    logic        in_handler;
    logic        irq_masked;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [2:0]  slot_index;
    logic        switched;
    logic [31:0] dispatch_handle;
    logic [31:0] stack_address;
    logic        all_done;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CSCAN,
    ST_YSCAN,
    ST_MUL,
    ST_OUT
  } state_t;

  // where a scan begins
  typedef enum logic [1:0] {
    SCAN_NONE,
    SCAN_FROM_ZERO,
    SCAN_FROM_CUR,
    SCAN_FROM_MAIN
  } scan_init_t;

  // how the result of a request is formed
  typedef enum logic [2:0] {
    FIN_IGNORED,
    FIN_NOSLOT,
    FIN_REFUSED,
    FIN_CREATED,
    FIN_CREATED_RUN,
    FIN_DISPATCH,
    FIN_ALLDONE
  } fin_t;

  typedef struct packed {
    logic       latch;
    logic       start_apply;
    logic       set_running;
    logic       stop_running;
    logic       free_cur;
    scan_init_t scan_init;
    logic       scan_step;
    logic       take_create;
    logic       take_dispatch;
    logic       fin_load;
    fin_t       fin;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       running;
    logic       blocked;
    logic       hit_create;
    logic       hit_ready;
    logic       scan_last;
  } dp_stat_t;

endpackage

### rtl/tsrrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsrrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/tsrrs_ctrl.sv
// Scheduler controller: request sequencing state machine.
module tsrrs_ctrl
  import tsrrs_pkg::*;
#(
  parameter bit PREALLOC_STACKS = 1'b1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  dp_stat_t  stat,
  output ctrl_cmd_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (stat.cmd)
          CMD_CREATE: state_nxt = ST_CSCAN;
          CMD_START:  state_nxt = (stat.running || stat.blocked) ? ST_OUT : ST_YSCAN;
          CMD_YIELD,
          CMD_EXIT:   state_nxt = (!stat.running || stat.blocked) ? ST_OUT : ST_YSCAN;
        endcase
      end
      ST_CSCAN: begin
        if (stat.hit_create) begin
          state_nxt = (stat.running && PREALLOC_STACKS) ? ST_MUL : ST_OUT;
        end else if (stat.scan_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_YSCAN: begin
        if (stat.hit_ready) begin
          state_nxt = ST_MUL;
        end else if (stat.scan_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_MUL:  state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl           = '0;
    ctl.scan_init = SCAN_NONE;
    ctl.fin       = FIN_IGNORED;
    unique case (state_r)
      ST_IDLE: begin
        ctl.latch = start;
      end
      ST_EXEC: begin
        unique case (stat.cmd)
          CMD_CREATE: ctl.scan_init = SCAN_FROM_ZERO;
          CMD_START: begin
            if (stat.running) begin
              ctl.fin_load = 1'b1;
            end else begin
              ctl.start_apply = 1'b1;
              if (stat.blocked) begin
                ctl.fin_load = 1'b1;
              end else begin
                ctl.set_running = 1'b1;
                ctl.scan_init   = SCAN_FROM_MAIN;
              end
            end
          end
          CMD_YIELD: begin
            if (!stat.running || stat.blocked) begin
              ctl.fin_load = 1'b1;
            end else begin
              ctl.scan_init = SCAN_FROM_CUR;
            end
          end
          CMD_EXIT: begin
            if (!stat.running) begin
              ctl.fin_load = 1'b1;
            end else begin
              ctl.free_cur = 1'b1;
              if (stat.blocked) begin
                ctl.fin_load = 1'b1;
              end else begin
                ctl.scan_init = SCAN_FROM_CUR;
              end
            end
          end
        endcase
      end
      ST_CSCAN: begin
        if (stat.hit_create) begin
          ctl.fin_load = 1'b1;
          if (stat.running && !PREALLOC_STACKS) begin
            ctl.fin = FIN_REFUSED;
          end else begin
            ctl.take_create = 1'b1;
            ctl.fin         = stat.running ? FIN_CREATED_RUN : FIN_CREATED;
          end
        end else if (stat.scan_last) begin
          ctl.fin_load = 1'b1;
          ctl.fin      = FIN_NOSLOT;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      ST_YSCAN: begin
        if (stat.hit_ready) begin
          ctl.take_dispatch = 1'b1;
          ctl.fin_load      = 1'b1;
          ctl.fin           = FIN_DISPATCH;
        end else if (stat.scan_last) begin
          ctl.stop_running = 1'b1;
          ctl.fin_load     = 1'b1;
          ctl.fin          = FIN_ALLDONE;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      ST_MUL: begin
      end
      ST_OUT: begin
        ctl.load_out = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

### rtl/tsrrs_dp.sv
// Scheduler datapath: slot table, scan pointer, stack address and result register.
module tsrrs_dp
  import tsrrs_pkg::*;
#(
  parameter int unsigned TASK_SLOTS          = 8,
  parameter int unsigned MAIN_SLOT           = 0,
  parameter int unsigned DEFAULT_STACK_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_req_t              in_req,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  ctrl_cmd_t            ctl,
  output dp_stat_t             stat,
  output logic                 out_strobe,
  output out_res_t             out_res
);

  localparam int unsigned SW = $clog2(TASK_SLOTS);
  localparam logic [SW-1:0] MAIN_IDX  = SW'(MAIN_SLOT % TASK_SLOTS);
  localparam logic [SW-1:0] LAST_IDX  = SW'(TASK_SLOTS - 1);
  localparam logic [15:0]   DEF_BYTES = 16'(DEFAULT_STACK_BYTES);

  // configuration
  logic [15:0] req_bytes_r;
  logic [31:0] base_r;

  // scheduler state
  logic [TASK_SLOTS-1:0] used_r, used_nxt;
  logic [TASK_SLOTS-1:0] ready_r, ready_nxt;
  logic [SW-1:0]         cur_r, cur_nxt;
  logic                  running_r, running_nxt;
  logic [15:0]           aligned_r, aligned_nxt;

  // per request
  in_req_t      req_r;
  fin_t         kind_r;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [SW+15:0] product_r;
  logic [31:0]    entry_rdata;

  logic     strobe_r;
  out_res_t res_r, res_nxt;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    next_slot = (s == LAST_IDX) ? '0 : s + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_bytes_r <= RESET_STACK_BYTES;
      base_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_REQ_STACK:  req_bytes_r <= cfg_wdata[15:0];
        CFG_IDX_STACK_BASE: base_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // slot table and scheduler state updates
  always_comb begin
    used_nxt    = used_r;
    ready_nxt   = ready_r;
    cur_nxt     = cur_r;
    running_nxt = running_r;
    aligned_nxt = aligned_r;
    if (ctl.start_apply) begin
      aligned_nxt = ((req_bytes_r < MIN_STACK_BYTES) ? DEF_BYTES : req_bytes_r)
                    & STACK_ALIGN_MASK;
      ready_nxt   = ready_r | used_r;
      cur_nxt     = MAIN_IDX;
    end
    if (ctl.set_running)  running_nxt = 1'b1;
    if (ctl.stop_running) running_nxt = 1'b0;
    if (ctl.free_cur) begin
      used_nxt[cur_r]  = 1'b0;
      ready_nxt[cur_r] = 1'b0;
    end
    if (ctl.take_create) begin
      used_nxt[idx_r]  = 1'b1;
      ready_nxt[idx_r] = running_r;
    end
    if (ctl.take_dispatch) cur_nxt = idx_r;
  end

  // scan pointer
  always_comb begin
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    case (ctl.scan_init)
      SCAN_FROM_ZERO: begin
        idx_nxt = '0;
        cnt_nxt = '0;
      end
      SCAN_FROM_CUR: begin
        idx_nxt = next_slot(cur_r);
        cnt_nxt = '0;
      end
      SCAN_FROM_MAIN: begin
        idx_nxt = next_slot(MAIN_IDX);
        cnt_nxt = '0;
      end
      default: begin
        if (ctl.scan_step) begin
          idx_nxt = next_slot(idx_r);
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      ready_r   <= '0;
      cur_r     <= '0;
      running_r <= 1'b0;
      aligned_r <= RESET_STACK_BYTES;
      strobe_r  <= 1'b0;
      idx_r     <= '0;
      cnt_r     <= '0;
    end else begin
      used_r    <= used_nxt;
      ready_r   <= ready_nxt;
      cur_r     <= cur_nxt;
      running_r <= running_nxt;
      aligned_r <= aligned_nxt;
      strobe_r  <= ctl.load_out;
      idx_r     <= idx_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch)    req_r  <= in_req;
    if (ctl.fin_load) kind_r <= ctl.fin;
    product_r <= aligned_r * idx_r;
    if (ctl.load_out) res_r <= res_nxt;
  end

  tsrrs_ram #(
    .WIDTH(32),
    .DEPTH(TASK_SLOTS)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ctl.take_create),
    .waddr(idx_r),
    .wdata(req_r.entry_handle),
    .raddr(idx_r),
    .rdata(entry_rdata)
  );

  // result assembly
  logic [SW-1:0]  slot_sel;
  logic [SW+2:0]  slot_ext;
  logic [31:0]    stack_sum;

  assign stack_sum = base_r + 32'(product_r);

  always_comb begin
    res_nxt  = '0;
    slot_sel = cur_r;
    case (kind_r)
      FIN_IGNORED: res_nxt.result_code = RC_IGNORED;
      FIN_NOSLOT: begin
        res_nxt.result_code = RC_NOSLOT;
        slot_sel            = '0;
      end
      FIN_REFUSED: begin
        res_nxt.result_code = RC_REFUSED;
        slot_sel            = idx_r;
      end
      FIN_CREATED: slot_sel = idx_r;
      FIN_CREATED_RUN: begin
        slot_sel              = idx_r;
        res_nxt.stack_address = stack_sum;
      end
      FIN_DISPATCH: begin
        slot_sel                = idx_r;
        res_nxt.switched        = 1'b1;
        res_nxt.dispatch_handle = entry_rdata;
        res_nxt.stack_address   = stack_sum;
      end
      FIN_ALLDONE: res_nxt.all_done = 1'b1;
      default: res_nxt.result_code = RC_IGNORED;
    endcase
    slot_ext           = {3'b000, slot_sel};
    res_nxt.slot_index = slot_ext[2:0];
  end

  assign stat.cmd        = req_r.cmd;
  assign stat.running    = running_r;
  assign stat.blocked    = req_r.in_handler | req_r.irq_masked;
  assign stat.hit_create = (idx_r != MAIN_IDX) && !used_r[idx_r];
  assign stat.hit_ready  = ready_r[idx_r];
  assign stat.scan_last  = (cnt_r == LAST_IDX);

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

  a_ready_implies_used: assert property (@(posedge clk) disable iff (!rst_n)
    (ready_r & ~used_r) == '0)
    else $error("ready slot not allocated");

  a_main_never_used: assert property (@(posedge clk) disable iff (!rst_n)
    !used_r[MAIN_IDX])
    else $error("main slot allocated");

  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r <= LAST_IDX) && (idx_r <= LAST_IDX))
    else $error("slot pointer out of range");

endmodule

### rtl/task_slot_round_robin_scheduler_top.sv
// Top level of the task slot round-robin scheduler.
//
// Usage:
//   A request (create, start, yield or task exit) is presented on in_req
//   and taken at a clock edge where start is high and busy is low. busy then
//   stays high until the request is finished; one request is in work at once.
//   Each request gives exactly one result on out_res, shown for a single
//   cycle with out_strobe high. The receiver cannot hold a result off.
//   Configuration (requested stack size, stack base) is written through
//   cfg_we / cfg_index / cfg_wdata while the block is idle.
// Sequencing: an ignored request goes from ST_EXEC straight to ST_OUT.
//   A create, or a start, yield or exit that is not ignored, first scans
//   the slot table from its start point, one entry per cycle, visiting
//   1 .. TASK_SLOTS slots. A create while running (PREALLOC_STACKS set)
//   and every dispatch then pass ST_MUL, which covers the registered entry
//   RAM read and the stack size multiply. A new request may be taken in
//   the cycle in which the strobe is shown.
// Reset: all slots free, current slot zero, not running, stack size 1024,
//   stack base zero. The entry RAM is not cleared; it is only read for
//   slots that have been created.
module task_slot_round_robin_scheduler_top
  import tsrrs_pkg::*;
#(
  parameter int unsigned TASK_SLOTS          = 8,
  parameter int unsigned MAIN_SLOT           = 0,
  parameter bit          PREALLOC_STACKS     = 1'b1,
  parameter int unsigned DEFAULT_STACK_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  in_req_t              in_req,
  // result channel
  output logic                 out_strobe,
  output out_res_t             out_res,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  // sequencing of each request
  tsrrs_ctrl #(
    .PREALLOC_STACKS(PREALLOC_STACKS)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .ctl  (ctl)
  );

  // slot table, scan pointer, stack address arithmetic, result register
  tsrrs_dp #(
    .TASK_SLOTS         (TASK_SLOTS),
    .MAIN_SLOT          (MAIN_SLOT),
    .DEFAULT_STACK_BYTES(DEFAULT_STACK_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .stat      (stat),
    .out_strobe(out_strobe),
    .out_res   (out_res)
  );

  // every request passes through ST_IDLE, ST_EXEC and ST_OUT, so strobes never abut
  a_strobe_isolated: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back to back result strobes");

  // a taken request holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // a result is never both a dispatch and the end of the run
  a_done_xor_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_res.switched && out_res.all_done))
    else $error("dispatch and all done together");

endmodule
